// ===== rtl/block_mapped_flash_translation_unit_defines.svh =====
// Assertion macros for the block-mapped flash translation unit.
// Used by the top level; expects a clock named clk and a reset named rst_n.
`ifndef BLOCK_MAPPED_FLASH_TRANSLATION_UNIT_DEFINES_SVH
`define BLOCK_MAPPED_FLASH_TRANSLATION_UNIT_DEFINES_SVH
`ifndef SYNTH
`define BMFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BMFT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BMFT_ASSERT_IMP(lbl, ante, cons, msg)
`define BMFT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/bmft_pkg.sv =====
// Shared types and constants of the block-mapped flash translation unit.
// No dependencies.
`timescale 1ns / 1ps
package bmft_pkg;
  localparam int LP_W   = 11;
  localparam int PAGE_W = 11;
  localparam int KIND_W = 3;

  localparam int DEF_PAGES_PER_BLK = 32;
  localparam int DEF_PHYS_BLOCKS   = 64;

  localparam logic [KIND_W-1:0] KIND_READ    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PROGRAM = 3'd1;
  localparam logic [KIND_W-1:0] KIND_COPY    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ERASE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic            op;
    logic [LP_W-1:0] logical_page;
  } bmft_in_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] phys_page;
    logic [PAGE_W-1:0] source_page;
    logic              last;
  } bmft_out_t;
endpackage

// ===== rtl/bmft_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module bmft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/bmft_div.sv =====
// Splits a logical page into block and offset by reciprocal multiplication; outputs are registered.
// Depends on bmft_pkg.
`timescale 1ns / 1ps
module bmft_div #(
  parameter int DIVISOR = 32,
  parameter int OFF_W   = $clog2(DIVISOR)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic [bmft_pkg::LP_W-1:0] dividend,
  output logic                   done,
  output logic [bmft_pkg::LP_W-1:0] quot,
  output logic [OFF_W-1:0]       rem
);
  import bmft_pkg::*;

  // q = (n * ceil(2^SH / d)) >> SH is exact for every n below 2^LP_W
  localparam int SH    = LP_W + $clog2(DIVISOR);
  localparam int RECIP = ((1 << SH) + DIVISOR - 1) / DIVISOR;
  localparam int MW    = 2 * LP_W + 1;

  logic [MW-1:0]    prod;
  logic [LP_W-1:0]  back;
  logic [LP_W-1:0]  quot_r, quot_nxt;
  logic [OFF_W-1:0] rem_r, rem_nxt;
  logic             done_r;

  always_comb begin
    prod     = MW'(dividend) * MW'(RECIP);
    quot_nxt = LP_W'(prod >> SH);
    back     = dividend - quot_nxt * LP_W'(DIVISOR);
    rem_nxt  = back[OFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;
endmodule

// ===== rtl/block_mapped_flash_translation_unit.sv =====
// Block-mapped flash translation unit: one request at a time, busy while working.
// Busy covers the whole request: an out-of-range check, a read, a program into a
// mapped block, a first write that scans up to PHYS_BLOCKS blocks, or an overwrite.
// A new request is taken while busy is low; results trail by one register.
// Reset (sync, rst_n low) starts a clear pass over both RAMs.
// Results come one per cycle at most as a strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`include "block_mapped_flash_translation_unit_defines.svh"
module block_mapped_flash_translation_unit #(
  parameter int PAGES_PER_BLK = bmft_pkg::DEF_PAGES_PER_BLK,
  parameter int PHYS_BLOCKS   = bmft_pkg::DEF_PHYS_BLOCKS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bmft_pkg::bmft_in_t in_data,
  output logic               out_valid,
  output bmft_pkg::bmft_out_t out_data
);
  import bmft_pkg::*;

  // widths derived from geometry
  localparam int OFF_W   = $clog2(PAGES_PER_BLK);
  localparam int PB_W    = $clog2(PHYS_BLOCKS);
  localparam int MAP_D   = PHYS_BLOCKS - 1;
  localparam int MAP_AW  = (MAP_D > 1) ? $clog2(MAP_D) : 1;
  localparam int MAP_W   = PB_W + 1;          // {mapped, physical block}
  localparam int PV_W    = PAGES_PER_BLK + 1; // {owned, page valid bits}
  localparam int PA_W    = PB_W + OFF_W;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,  // post-reset sweep of both RAMs
    S_IDLE  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,  // split page into block and offset
    S_MAP   = 8'b0000_1000,  // map entry on RAM output
    S_SCAN  = 8'b0001_0000,  // search for lowest free block
    S_PV    = 8'b0010_0000,  // valid bits of the mapped block
    S_COPY  = 8'b0100_0000,  // one page per cycle
    S_ERASE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [PB_W-1:0]          clr_r, clr_nxt;
  logic                     op_r, op_nxt;
  logic [MAP_AW-1:0]        lbn_r, lbn_nxt;
  logic [OFF_W-1:0]         off_r, off_nxt;
  logic [PB_W-1:0]          pbn_r, pbn_nxt;   // target block, also scan pointer
  logic [PB_W-1:0]          old_r, old_nxt;
  logic [PB_W-1:0]          spare_r, spare_nxt;
  logic [PAGES_PER_BLK-1:0] bits_r, bits_nxt;
  logic [OFF_W-1:0]         idx_r, idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  bmft_out_t                out_data_r, out_data_nxt;

  // memory ports
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic [MAP_W-1:0]  map_wdata, map_rdata;
  logic              pv_we;
  logic [PB_W-1:0]   pv_waddr, pv_raddr;
  logic [PV_W-1:0]   pv_wdata, pv_rdata;

  // divider
  logic              div_go, div_done;
  logic [LP_W-1:0]   div_quot;
  logic [OFF_W-1:0]  div_rem;

  logic              accept;
  logic [PAGES_PER_BLK-1:0] off_bit;

  function automatic logic [PAGE_W-1:0] page_of(input logic [PB_W-1:0] blk,
                                                input logic [OFF_W-1:0] pg);
    logic [PA_W-1:0] prod;
    prod = PA_W'(blk) * PA_W'(PAGES_PER_BLK) + PA_W'(pg);
    return PAGE_W'(prod);
  endfunction

  bmft_ram #(.WIDTH(MAP_W), .DEPTH(MAP_D), .AW(MAP_AW)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  bmft_ram #(.WIDTH(PV_W), .DEPTH(PHYS_BLOCKS), .AW(PB_W)) u_pv_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (pv_raddr),
    .rdata (pv_rdata)
  );

  bmft_div #(.DIVISOR(PAGES_PER_BLK), .OFF_W(OFF_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (in_data.logical_page),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign div_go  = accept;
  assign off_bit = PAGES_PER_BLK'(1) << off_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    lbn_nxt       = lbn_r;
    off_nxt       = off_r;
    pbn_nxt       = pbn_r;
    old_nxt       = old_r;
    spare_nxt     = spare_r;
    bits_nxt      = bits_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    map_we        = 1'b0;
    map_waddr     = lbn_r;
    map_wdata     = '0;
    map_raddr     = lbn_r;
    pv_we         = 1'b0;
    pv_waddr      = pbn_r;
    pv_wdata      = '0;
    pv_raddr      = pbn_r;

    unique case (state_r)
      S_CLEAR: begin
        pv_we     = 1'b1;
        pv_waddr  = clr_r;
        map_we    = (clr_r < PB_W'(MAP_D));
        map_waddr = clr_r[MAP_AW-1:0];
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == PB_W'(PHYS_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_data.op;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          off_nxt   = div_rem;
          lbn_nxt   = div_quot[MAP_AW-1:0];
          map_raddr = div_quot[MAP_AW-1:0];
          if (div_quot >= LP_W'(MAP_D)) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.kind      = KIND_ERROR;
            out_data_nxt.last      = 1'b1;
            state_nxt              = S_IDLE;
          end else begin
            state_nxt = S_MAP;
          end
        end
      end
      S_MAP: begin
        if (!map_rdata[PB_W]) begin
          if (op_r == OP_READ) begin
            out_valid_nxt     = 1'b1;
            out_data_nxt.kind = KIND_ERROR;
            out_data_nxt.last = 1'b1;
            state_nxt         = S_IDLE;
          end else begin
            pbn_nxt   = '0;
            pv_raddr  = '0;
            state_nxt = S_SCAN;
          end
        end else if (op_r == OP_READ) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.kind      = KIND_READ;
          out_data_nxt.phys_page = page_of(map_rdata[PB_W-1:0], off_r);
          out_data_nxt.last      = 1'b1;
          state_nxt              = S_IDLE;
        end else begin
          pbn_nxt   = map_rdata[PB_W-1:0];
          pv_raddr  = map_rdata[PB_W-1:0];
          state_nxt = S_PV;
        end
      end
      S_SCAN: begin
        // owner bit tracks whether a logical block maps here
        if (!pv_rdata[PAGES_PER_BLK] && pbn_r != spare_r) begin
          map_we                 = 1'b1;
          map_wdata              = {1'b1, pbn_r};
          pv_we                  = 1'b1;
          pv_wdata               = {1'b1, off_bit};
          out_valid_nxt          = 1'b1;
          out_data_nxt.kind      = KIND_PROGRAM;
          out_data_nxt.phys_page = page_of(pbn_r, off_r);
          out_data_nxt.last      = 1'b1;
          state_nxt              = S_IDLE;
        end else if (pbn_r == PB_W'(PHYS_BLOCKS - 1)) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt.kind = KIND_ERROR;
          out_data_nxt.last = 1'b1;
          state_nxt         = S_IDLE;
        end else begin
          pbn_nxt  = pbn_r + 1'b1;
          pv_raddr = pbn_r + 1'b1;
        end
      end
      S_PV: begin
        if (!pv_rdata[off_r]) begin
          pv_we                  = 1'b1;
          pv_wdata               = pv_rdata | {1'b0, off_bit};
          out_valid_nxt          = 1'b1;
          out_data_nxt.kind      = KIND_PROGRAM;
          out_data_nxt.phys_page = page_of(pbn_r, off_r);
          out_data_nxt.last      = 1'b1;
          state_nxt              = S_IDLE;
        end else begin
          // swap with spare; spare inherits the valid bits
          old_nxt                = pbn_r;
          pbn_nxt                = spare_r;
          spare_nxt              = pbn_r;
          bits_nxt               = pv_rdata[PAGES_PER_BLK-1:0];
          map_we                 = 1'b1;
          map_wdata              = {1'b1, spare_r};
          pv_we                  = 1'b1;
          pv_waddr               = spare_r;
          pv_wdata               = {1'b1, pv_rdata[PAGES_PER_BLK-1:0]};
          out_valid_nxt          = 1'b1;
          out_data_nxt.kind      = KIND_PROGRAM;
          out_data_nxt.phys_page = page_of(spare_r, off_r);
          idx_nxt                = '0;
          state_nxt              = S_COPY;
        end
      end
      S_COPY: begin
        if (idx_r != off_r && bits_r[idx_r]) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = KIND_COPY;
          out_data_nxt.phys_page   = page_of(pbn_r, idx_r);
          out_data_nxt.source_page = page_of(old_r, idx_r);
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == OFF_W'(PAGES_PER_BLK - 1)) begin
          state_nxt = S_ERASE;
        end
      end
      S_ERASE: begin
        pv_we                  = 1'b1;
        pv_waddr               = old_r;
        out_valid_nxt          = 1'b1;
        out_data_nxt.kind      = KIND_ERASE;
        out_data_nxt.phys_page = page_of(old_r, '0);
        out_data_nxt.last      = 1'b1;
        state_nxt              = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      spare_r     <= PB_W'(PHYS_BLOCKS - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      spare_r     <= spare_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    lbn_r      <= lbn_nxt;
    off_r      <= off_nxt;
    pbn_r      <= pbn_nxt;
    old_r      <= old_nxt;
    bits_r     <= bits_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BMFT_ASSERT_IMP(a_err_last, out_valid_r && out_data_r.kind == KIND_ERROR, out_data_r.last, "error result without last")
  `BMFT_ASSERT_NXT(a_no_early_rsp, accept, !out_valid_r, "result right after request accept")
  `BMFT_ASSERT_IMP(a_last_idle, out_valid_r && out_data_r.last, state_r == S_IDLE, "last result while still busy")
  `BMFT_ASSERT_IMP(a_clear_quiet, state_r == S_CLEAR, !out_valid_r, "result during clear pass")
endmodule

// ===== test/tb_block_mapped_flash_translation_unit.sv =====
// Testbench for the block-mapped flash translation unit: directed table, a full-block overwrite, then random requests.
// Depends on bmft_pkg and the block_mapped_flash_translation_unit RTL.
`timescale 1ns / 1ps
module tb_block_mapped_flash_translation_unit;
  import bmft_pkg::*;

  localparam int PPB        = DEF_PAGES_PER_BLK;
  localparam int NBLK       = DEF_PHYS_BLOCKS;
  localparam int NDATA      = NBLK - 1;
  localparam int N_RANDOM   = 500;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 200;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  bmft_in_t  in_data;
  logic      out_valid;
  bmft_out_t out_data;

  block_mapped_flash_translation_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Predictor state: logical-to-physical map, spare block, per-block page bitmap.
  logic            map_ok [NDATA];
  int unsigned     map_pb [NDATA];
  int unsigned     spare_pb;
  logic [PPB-1:0]  valid_pages [NBLK];

  bmft_out_t flash_cmds_due[$];
  int        err_count;
  int        cycle_count;

  // Directed rows; a known expectation, where given, is checked against the prediction.
  typedef struct {
    logic      op;
    int        lp;
    logic      has_known;
    bmft_out_t known;
  } dir_row_t;

  function automatic bmft_out_t mk_cmd(logic [KIND_W-1:0] k, int unsigned pg,
                                       int unsigned src, logic lst);
    bmft_out_t c;
    c.kind        = k;
    c.phys_page   = pg[PAGE_W-1:0];
    c.source_page = src[PAGE_W-1:0];
    c.last        = lst;
    return c;
  endfunction

  // Works out the flash commands of one request and updates the mapping.
  function automatic void translate_request(logic op, int unsigned lp);
    int unsigned lbn;
    int unsigned off;
    int unsigned pbn;
    int unsigned old;
    int unsigned free_pb;
    logic        found;
    logic        used;
    bmft_out_t   cmds[$];
    lbn = lp / PPB;
    off = lp % PPB;
    if (lbn >= NDATA) begin
      flash_cmds_due.push_back(mk_cmd(KIND_ERROR, 0, 0, 1'b1));
      return;
    end
    if (op == OP_READ) begin
      if (!map_ok[lbn])
        flash_cmds_due.push_back(mk_cmd(KIND_ERROR, 0, 0, 1'b1));
      else
        flash_cmds_due.push_back(mk_cmd(KIND_READ, map_pb[lbn] * PPB + off, 0, 1'b1));
      return;
    end
    if (!map_ok[lbn]) begin
      found = 1'b0;
      free_pb = 0;
      for (int pb = 0; pb < NBLK && !found; pb++) begin
        used = 1'b0;
        for (int i = 0; i < NDATA; i++)
          if (map_ok[i] && map_pb[i] == pb) used = 1'b1;
        if (pb != spare_pb && !used) begin
          found = 1'b1;
          free_pb = pb;
        end
      end
      if (!found) begin
        flash_cmds_due.push_back(mk_cmd(KIND_ERROR, 0, 0, 1'b1));
        return;
      end
      map_pb[lbn] = free_pb;
      map_ok[lbn] = 1'b1;
    end
    pbn = map_pb[lbn] % NBLK;
    if (!valid_pages[pbn][off]) begin
      valid_pages[pbn][off] = 1'b1;
      flash_cmds_due.push_back(mk_cmd(KIND_PROGRAM, pbn * PPB + off, 0, 1'b1));
      return;
    end
    // Overwrite: swap with spare, program, copy the rest, erase the old block.
    old = pbn;
    pbn = spare_pb % NBLK;
    spare_pb = old;
    map_pb[lbn] = pbn;
    cmds.push_back(mk_cmd(KIND_PROGRAM, pbn * PPB + off, 0, 1'b0));
    for (int i = 0; i < PPB; i++)
      if (i != off && valid_pages[old][i])
        cmds.push_back(mk_cmd(KIND_COPY, pbn * PPB + i, old * PPB + i, 1'b0));
    cmds.push_back(mk_cmd(KIND_ERASE, old * PPB, 0, 1'b1));
    foreach (cmds[i]) flash_cmds_due.push_back(cmds[i]);
    valid_pages[pbn] = valid_pages[old];
    valid_pages[old] = '0;
  endfunction

  // Result checker: the receiver never stalls, so every strobe is a result.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (flash_cmds_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        err_count++;
      end else begin
        bmft_out_t want;
        want = flash_cmds_due.pop_front();
        if (out_data.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_data.kind);
          err_count++;
        end
        if (out_data.phys_page !== want.phys_page) begin
          $display("%0t: phys_page expected %0d actual %0d", $time, want.phys_page,
                   out_data.phys_page);
          err_count++;
        end
        if (out_data.source_page !== want.source_page) begin
          $display("%0t: source_page expected %0d actual %0d", $time, want.source_page,
                   out_data.source_page);
          err_count++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_data.last);
          err_count++;
        end
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_block_mapped_flash_translation_unit: errors");
      $finish;
    end
  end

  // Mostly short idle gaps, sometimes long, sometimes none.
  task automatic idle_gap();
    int n;
    n = 0;
    case ($urandom_range(0, 9)) inside
      [0:3]: n = 0;
      [4:8]: n = $urandom_range(1, 3);
      default: n = $urandom_range(10, 60);
    endcase
    repeat (n) @(posedge clk);
  endtask

  // Issue one request: raise start and hold it until busy is sampled low, then drop start
  // before returning, so the next request drives a fresh start.
  task automatic send_request(logic op, int unsigned lp);
    bmft_in_t req;
    req.op = op;
    req.logical_page = lp[LP_W-1:0];
    in_data <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    translate_request(op, lp);
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Random page: mostly within a few logical blocks so overwrites happen often.
  function automatic int unsigned pick_page();
    case ($urandom_range(0, 19)) inside
      0: return $urandom_range(NDATA * PPB, 2047); // out of range
      [1:2]: return $urandom_range(0, 2047);
      default: return $urandom_range(0, 5) * PPB + $urandom_range(0, PPB - 1);
    endcase
  endfunction

  dir_row_t dir_rows[$];
  int       wait_cnt;

  initial begin
    err_count   = 0;
    cycle_count = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    for (int i = 0; i < NDATA; i++) begin
      map_ok[i] = 1'b0;
      map_pb[i] = 0;
    end
    for (int i = 0; i < NBLK; i++) valid_pages[i] = '0;
    spare_pb = NBLK - 1;

    // Directed part: error cases, first writes, reads, overwrites.
    dir_rows = '{
      '{OP_READ,  0,    1'b1, mk_cmd(KIND_ERROR, 0, 0, 1'b1)},    // unmapped read
      '{OP_READ,  2047, 1'b1, mk_cmd(KIND_ERROR, 0, 0, 1'b1)},    // block out of range
      '{OP_WRITE, 2047, 1'b1, mk_cmd(KIND_ERROR, 0, 0, 1'b1)},
      '{OP_WRITE, 2016, 1'b1, mk_cmd(KIND_ERROR, 0, 0, 1'b1)},    // first out-of-range page
      '{OP_WRITE, 0,    1'b1, mk_cmd(KIND_PROGRAM, 0, 0, 1'b1)},  // maps block 0
      '{OP_READ,  0,    1'b1, mk_cmd(KIND_READ, 0, 0, 1'b1)},
      '{OP_READ,  31,   1'b1, mk_cmd(KIND_READ, 31, 0, 1'b1)},    // mapped, never written
      '{OP_WRITE, 31,   1'b0, '0},
      '{OP_WRITE, 2015, 1'b0, '0},                                // last logical page
      '{OP_WRITE, 0,    1'b0, '0},                                // overwrite with copy
      '{OP_READ,  0,    1'b0, '0},
      '{OP_WRITE, 2015, 1'b0, '0},                                // overwrite, no copies
      '{OP_READ,  2015, 1'b0, '0},
      '{OP_WRITE, 1024, 1'b0, '0},
      '{OP_READ,  1055, 1'b0, '0}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      send_request(dir_rows[r].op, dir_rows[r].lp);
      if (dir_rows[r].has_known && flash_cmds_due[$] != dir_rows[r].known) begin
        $display("%0t: row %0d expected %p actual prediction %p", $time, r,
                 dir_rows[r].known, flash_cmds_due[$]);
        err_count++;
      end
      idle_gap();
    end

    // Fill a whole block so an overwrite copies 31 pages.
    for (int p = 0; p < PPB; p++) send_request(OP_WRITE, 3 * PPB + p);
    send_request(OP_WRITE, 3 * PPB + 7);

    // Random part: writes dominate, so blocks fill and get moved.
    for (int n = 0; n < N_RANDOM; n++) begin
      send_request(($urandom_range(0, 9) < 6) ? OP_WRITE : OP_READ, pick_page());
      if ($urandom_range(0, 3) != 0) idle_gap();
    end

    wait_cnt = 0;
    while (flash_cmds_due.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0 && flash_cmds_due.size() == 0) begin
      $display("tb_block_mapped_flash_translation_unit: clean");
    end else begin
      if (flash_cmds_due.size() != 0)
        $display("%0t: %0d results never arrived, next expected %p", $time,
                 flash_cmds_due.size(), flash_cmds_due[0]);
      $display("tb_block_mapped_flash_translation_unit: errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/bmft_pkg.sv
rtl/bmft_ram.sv
rtl/bmft_div.sv
rtl/block_mapped_flash_translation_unit.sv
test/tb_block_mapped_flash_translation_unit.sv
